// ----- rtl/otc_pkg.sv -----
// ----------------------------------------------------------------------------
// otc_pkg
// Shared widths and types for the online threshold clusterer.
// ----------------------------------------------------------------------------
`default_nettype none

package otc_pkg;

    localparam int CRD_W = 16;   // Q8.8 coordinate
    localparam int SUM_W = 28;   // per-axis coordinate sum
    localparam int CNT_W = 10;   // member count, limit is at most 1000
    localparam int CFG_W = 16;   // widest config register
    localparam int SQ_W  = 2 * CRD_W;

    localparam logic REG_THRESHOLD     = 1'b0;
    localparam logic REG_BRANCH_FACTOR = 1'b1;

    localparam logic [6:0] BRANCH_MIN = 7'd2;
    localparam logic [6:0] BRANCH_MAX = 7'd100;

    // Tag that travels with one centroid element through the distance unit
    typedef struct packed {
        logic valid;
        logic last;     // last axis of the entry
    } dist_tag_t;

endpackage

`default_nettype wire

// ----- rtl/otc_div.sv -----
// ----------------------------------------------------------------------------
// otc_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Produces the centroid coordinate sum / count.
// ----------------------------------------------------------------------------
`default_nettype none

module otc_div
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [otc_pkg::SUM_W-1:0]   dividend,
    input  wire logic [otc_pkg::CNT_W-1:0]          divisor,
    output logic                                    done,
    output logic signed [otc_pkg::CRD_W-1:0]        quotient
);
    import otc_pkg::*;

    localparam int IW = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [IW-1:0]     iter_reg;
    logic [SUM_W-1:0]  q_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic              neg_reg;

    logic [CNT_W:0]    rem_sh;
    logic              ge;
    logic [CRD_W-1:0]  q_lo;

    assign rem_sh = {rem_reg[CNT_W-1:0], q_reg[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign q_lo   = q_reg[CRD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= IW'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            q_reg   <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            q_reg   <= {q_reg[SUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-q_lo) : $signed(q_lo);

endmodule

`default_nettype wire

// ----- rtl/otc_dist.sv -----
// ----------------------------------------------------------------------------
// otc_dist
// Squared-distance unit: one axis per cycle through a shared multiplier,
// accumulated per entry; reports the entry distance after its last axis.
// ----------------------------------------------------------------------------
`default_nettype none

module otc_dist
#(
    parameter int DIST_W = 35
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire otc_pkg::dist_tag_t                 tag,       // with address issue
    input  wire logic signed [otc_pkg::CRD_W-1:0]   pt_coord,  // with address issue
    input  wire logic signed [otc_pkg::CRD_W-1:0]   cent,      // in the cycle after issue
    output logic                                    entry_done,
    output logic [DIST_W-1:0]                       entry_dist
);
    import otc_pkg::*;

    dist_tag_t                t1_reg;
    dist_tag_t                t2_reg;
    logic signed [CRD_W-1:0]  pt1_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [DIST_W-1:0]        acc_reg;
    logic                     done_reg;
    logic [DIST_W-1:0]        dist_reg;

    logic signed [CRD_W:0]    diff;
    logic signed [2*CRD_W+1:0] prod;
    logic [DIST_W-1:0]        acc_sum;

    assign diff    = (CRD_W+1)'(pt1_reg) - (CRD_W+1)'(cent);
    assign prod    = diff * diff;
    assign acc_sum = acc_reg + DIST_W'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            done_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            t1_reg   <= tag;
            t2_reg   <= t1_reg;
            done_reg <= t2_reg.valid && t2_reg.last;
            if (t2_reg.valid)
                acc_reg <= t2_reg.last ? '0 : acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        pt1_reg <= pt_coord;
        sq_reg  <= prod[SQ_W-1:0];
        if (t2_reg.valid && t2_reg.last)
            dist_reg <= acc_sum;
    end

    assign entry_done = done_reg;
    assign entry_dist = dist_reg;

endmodule

`default_nettype wire

// ----- rtl/online_threshold_clusterer.sv -----
// ----------------------------------------------------------------------------
// online_threshold_clusterer
// Leaf-level threshold clustering of Q8.8 points into a subcluster table.
// ----------------------------------------------------------------------------
// Takes one point at a time and returns one result per point. After acceptance
// the scan feeds one centroid axis per cycle through the shared squared-distance
// multiplier and then lets the pipeline drain; on an empty table it ends at
// once. S_CNT reads the member count and S_DECIDE decides, then S_NEW opens a
// new subcluster axis by axis, or S_SUM_RD, S_SUM_ADD and S_DIV absorb the point
// axis by axis, where the bit-serial divider recomputes each centroid axis.
// S_DONE loads the result register, and the block then returns to idle to take
// the next point. pt_ready is low while a point is in work, and a result that is
// not taken holds the block before it loads the next one. Centroids are kept in
// their own memory, so the scan needs no division.
`default_nettype none

module online_threshold_clusterer
#(
    parameter int MAX_CLUSTERS = 64,
    parameter int DIM          = 4
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic                                   cfg_index,
    input  wire logic [otc_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                   pt_valid,
    output logic                                        pt_ready,
    input  wire logic signed [otc_pkg::CRD_W-1:0]       coord_0,
    input  wire logic signed [otc_pkg::CRD_W-1:0]       coord_1,
    input  wire logic signed [otc_pkg::CRD_W-1:0]       coord_2,
    input  wire logic signed [otc_pkg::CRD_W-1:0]       coord_3,
    input  wire logic                                   last_point,
    output logic                                        res_valid,
    input  wire logic                                   res_ready,
    output logic [$clog2(MAX_CLUSTERS)-1:0]             cluster_index,
    output logic                                        created_new,
    output logic                                        dropped,
    output logic [$clog2(MAX_CLUSTERS+1)-1:0]           cluster_count,
    output logic                                        set_done
);
    import otc_pkg::*;

    localparam int CW     = $clog2(MAX_CLUSTERS);
    localparam int NW     = $clog2(MAX_CLUSTERS + 1);
    localparam int DEPTH  = MAX_CLUSTERS * DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int DW     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int DIST_W = SQ_W + $clog2(DIM + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_CNT     = 4'd2;
    localparam logic [3:0] S_DECIDE  = 4'd3;
    localparam logic [3:0] S_NEW     = 4'd4;
    localparam logic [3:0] S_SUM_RD  = 4'd5;
    localparam logic [3:0] S_SUM_ADD = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    // control
    logic [3:0]       state_reg;
    logic [DW-1:0]    d_reg;
    logic [NW-1:0]    scan_c_reg;
    logic [NW-1:0]    cmp_c_reg;
    logic [NW-1:0]    used_reg;
    logic             res_valid_reg;
    logic [2*CFG_W-1:0] thr_sq_reg;
    logic [6:0]       branch_reg;

    // payload
    logic signed [CRD_W-1:0] pt_reg [DIM];
    logic                    last_reg;
    logic [CW-1:0]           best_reg;
    logic [DIST_W-1:0]       best_dist_reg;
    logic [CW-1:0]           tgt_reg;
    logic                    made_reg;
    logic                    drop_reg;
    logic [CNT_W-1:0]        cnt_new_reg;
    logic [CW-1:0]           o_idx_reg;
    logic                    o_made_reg;
    logic                    o_drop_reg;
    logic [NW-1:0]           o_count_reg;
    logic                    o_done_reg;

    // memories
    logic signed [CRD_W-1:0] cent_mem [DEPTH];
    logic signed [SUM_W-1:0] sum_mem  [DEPTH];
    logic [CNT_W-1:0]        cnt_mem  [MAX_CLUSTERS];
    logic signed [CRD_W-1:0] cent_rd_reg;
    logic signed [SUM_W-1:0] sum_rd_reg;
    logic [CNT_W-1:0]        cnt_rd_reg;

    logic signed [CRD_W-1:0] pt_in [DIM];
    logic signed [CRD_W-1:0] pt_sel;
    logic                    d_last;
    logic                    accept;
    logic                    scan_issue;
    logic                    scan_over;
    logic [AW-1:0]           scan_addr;
    logic [AW-1:0]           tgt_addr;
    logic signed [SUM_W-1:0] sum_new;
    logic [CNT_W-1:0]        limit;
    logic                    absorb;
    logic                    table_full;
    logic                    out_free;
    logic [CFG_W-1:0]        thr_clamp;
    logic [6:0]              br_clamp;
    dist_tag_t               tag;
    logic                    entry_done;
    logic [DIST_W-1:0]       entry_dist;
    logic                    div_start;
    logic                    div_done;
    logic signed [CRD_W-1:0] div_q;
    logic                    cent_we;
    logic signed [CRD_W-1:0] cent_wdata;
    logic                    sum_we;
    logic signed [SUM_W-1:0] sum_wdata;
    logic                    cnt_we;
    logic [CW-1:0]           cnt_waddr;
    logic [CNT_W-1:0]        cnt_wdata;

    always_comb
    begin
        for (int d = 0; d < DIM; d++)
        begin
            case (d)
                0:       pt_in[d] = coord_0;
                1:       pt_in[d] = coord_1;
                2:       pt_in[d] = coord_2;
                3:       pt_in[d] = coord_3;
                default: pt_in[d] = '0;
            endcase
        end
    end

    assign pt_sel     = pt_reg[d_reg];
    assign d_last     = d_reg == DW'(DIM - 1);
    assign accept     = pt_valid && pt_ready;
    assign pt_ready   = state_reg == S_IDLE;
    assign scan_issue = (state_reg == S_SCAN) && (scan_c_reg < used_reg);
    assign scan_over  = (state_reg == S_SCAN) && (cmp_c_reg == used_reg);
    assign scan_addr  = AW'(scan_c_reg[CW-1:0]) * AW'(DIM) + AW'(d_reg);
    assign tgt_addr   = AW'(tgt_reg) * AW'(DIM) + AW'(d_reg);
    assign sum_new    = sum_rd_reg + SUM_W'(pt_sel);
    assign limit      = CNT_W'(branch_reg) * CNT_W'(10);
    assign table_full = used_reg == NW'(MAX_CLUSTERS);
    // the distance is always wider than the squared threshold
    assign absorb     = (used_reg != '0)
                        && (best_dist_reg < DIST_W'(thr_sq_reg))
                        && (cnt_rd_reg < limit);
    assign out_free   = !res_valid_reg || res_ready;
    assign thr_clamp  = (cfg_data == '0) ? CFG_W'(1) : cfg_data;
    assign br_clamp   = (cfg_data[6:0] < BRANCH_MIN) ? BRANCH_MIN :
                        (cfg_data[6:0] > BRANCH_MAX) ? BRANCH_MAX : cfg_data[6:0];

    assign tag.valid  = scan_issue;
    assign tag.last   = d_last;
    assign div_start  = state_reg == S_SUM_ADD;

    assign cent_we    = (state_reg == S_NEW) || ((state_reg == S_DIV) && div_done);
    assign cent_wdata = (state_reg == S_NEW) ? pt_sel : div_q;
    assign sum_we     = (state_reg == S_NEW) || (state_reg == S_SUM_ADD);
    assign sum_wdata  = (state_reg == S_NEW) ? SUM_W'(pt_sel) : sum_new;
    assign cnt_we     = (state_reg == S_DECIDE) && (absorb || !table_full);
    assign cnt_waddr  = absorb ? best_reg : used_reg[CW-1:0];
    assign cnt_wdata  = absorb ? (cnt_rd_reg + 1'b1) : CNT_W'(1);

    otc_dist #(.DIST_W(DIST_W)) u_dist
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag),
        .pt_coord   (pt_sel),
        .cent       (cent_rd_reg),
        .entry_done (entry_done),
        .entry_dist (entry_dist)
    );

    otc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_new),
        .divisor  (cnt_new_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        cent_rd_reg <= cent_mem[scan_addr];
        sum_rd_reg  <= sum_mem[tgt_addr];
        cnt_rd_reg  <= cnt_mem[best_reg];
        if (cent_we)
            cent_mem[tgt_addr] <= cent_wdata;
        if (sum_we)
            sum_mem[tgt_addr] <= sum_wdata;
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            d_reg         <= '0;
            scan_c_reg    <= '0;
            cmp_c_reg     <= '0;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
            thr_sq_reg    <= 32'd65536;
            branch_reg    <= 7'd10;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD:     thr_sq_reg <= thr_clamp * thr_clamp;
                    REG_BRANCH_FACTOR: branch_reg <= br_clamp;
                    default:           ;
                endcase
            end

            if ((state_reg == S_DONE) && out_free)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;

            if (accept)
                cmp_c_reg <= '0;
            else if (entry_done)
                cmp_c_reg <= cmp_c_reg + 1'b1;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg  <= S_SCAN;
                        d_reg      <= '0;
                        scan_c_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (scan_issue)
                    begin
                        if (d_last)
                        begin
                            d_reg      <= '0;
                            scan_c_reg <= scan_c_reg + 1'b1;
                        end
                        else
                            d_reg <= d_reg + 1'b1;
                    end
                    if (scan_over)
                        state_reg <= S_CNT;
                end
                S_CNT:
                    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    d_reg <= '0;
                    if (absorb)
                        state_reg <= S_SUM_RD;
                    else if (!table_full)
                    begin
                        used_reg  <= used_reg + 1'b1;
                        state_reg <= S_NEW;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_NEW:
                begin
                    d_reg <= d_reg + 1'b1;
                    if (d_last)
                        state_reg <= S_DONE;
                end
                S_SUM_RD:
                    state_reg <= S_SUM_ADD;
                S_SUM_ADD:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= d_last ? S_DONE : S_SUM_RD;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        if (last_reg)
                            used_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int d = 0; d < DIM; d++)
                pt_reg[d] <= pt_in[d];
            last_reg <= last_point;
        end
        // first entry always wins, then strictly smaller keeps lowest index
        if (entry_done && ((cmp_c_reg == '0) || (entry_dist < best_dist_reg)))
        begin
            best_dist_reg <= entry_dist;
            best_reg      <= cmp_c_reg[CW-1:0];
        end
        if (state_reg == S_DECIDE)
        begin
            made_reg    <= !absorb && !table_full;
            drop_reg    <= !absorb && table_full;
            cnt_new_reg <= cnt_rd_reg + 1'b1;
            tgt_reg     <= absorb ? best_reg : (table_full ? '0 : used_reg[CW-1:0]);
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            o_idx_reg   <= tgt_reg;
            o_made_reg  <= made_reg;
            o_drop_reg  <= drop_reg;
            o_count_reg <= used_reg;
            o_done_reg  <= last_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign cluster_index = o_idx_reg;
    assign created_new   = o_made_reg;
    assign dropped       = o_drop_reg;
    assign cluster_count = o_count_reg;
    assign set_done      = o_done_reg;

endmodule

`default_nettype wire

// ----- rtl/otc_checker.sv -----
// ----------------------------------------------------------------------------
// otc_checker
// Port-level checks for the online threshold clusterer.
// ----------------------------------------------------------------------------
`default_nettype none

module otc_checker
#(
    parameter int MAX_CLUSTERS = 64
)
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              pt_valid,
    input wire logic                              pt_ready,
    input wire logic                              res_valid,
    input wire logic                              res_ready,
    input wire logic [$clog2(MAX_CLUSTERS)-1:0]   cluster_index,
    input wire logic                              created_new,
    input wire logic                              dropped,
    input wire logic [$clog2(MAX_CLUSTERS+1)-1:0] cluster_count
);

    // a stalled result transaction stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before transaction");

    // one point in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && pt_ready |=> !pt_ready)
        else $error("point accepted while busy");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && dropped |->
            !created_new && cluster_index == '0
            && cluster_count == ($clog2(MAX_CLUSTERS+1))'(MAX_CLUSTERS))
        else $error("drop with table not full");

    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && created_new |->
            cluster_count == ($clog2(MAX_CLUSTERS+1))'(cluster_index) + 1'b1)
        else $error("new subcluster index does not match count");

endmodule

bind online_threshold_clusterer otc_checker #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_otc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .pt_valid      (pt_valid),
    .pt_ready      (pt_ready),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .cluster_index (cluster_index),
    .created_new   (created_new),
    .dropped       (dropped),
    .cluster_count (cluster_count)
);

`default_nettype wire

// ----- test/online_threshold_clusterer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// online_threshold_clusterer_tb
// Self-checking bench for the leaf-level threshold clusterer.
// ----------------------------------------------------------------------------
// Streams data sets of Q8.8 points through the block under several threshold
// and branch settings and with random gaps on both channels. A scoreboard keeps
// its own subcluster table, predicts each point's assignment and compares it
// with every result transaction in order.
`default_nettype none

typedef struct {
    logic [5:0] cluster_index;
    logic       created_new;
    logic       dropped;
    logic [6:0] cluster_count;
    logic       set_done;
} assign_t;

class cluster_scoreboard;
    longint      sums [64][4];
    int unsigned members [64];
    int unsigned used;
    int unsigned thr;
    int unsigned branch;
    assign_t     expected_q [$];
    int          errors;

    function new();
        used   = 0;
        thr    = 256;
        branch = 10;
        errors = 0;
    endfunction

    function void set_register(logic idx, logic [15:0] data);
        int unsigned b;
        if (idx == otc_pkg::REG_THRESHOLD)
            thr = (data == 0) ? 1 : data;
        else
        begin
            b = data[6:0];
            if (b < 2) b = 2;
            if (b > 100) b = 100;
            branch = b;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Assign one accepted point and queue the result it must produce.
    function void note_point(logic [3:0][15:0] crd, logic last);
        longint  pt [4];
        longint  sq_dist, best_dist, cent, diff;
        int      best;
        bit      found;
        assign_t r;
        found = 0;
        best = 0;
        best_dist = 0;
        r = '{default: 0};
        for (int d = 0; d < 4; d++)
            pt[d] = longint'($signed(crd[d]));
        for (int c = 0; c < used; c++)
        begin
            sq_dist = 0;
            for (int d = 0; d < 4; d++)
            begin
                cent = (members[c] > 0) ? sums[c][d] / longint'(members[c]) : 0;
                diff = pt[d] - cent;
                sq_dist += diff * diff;
            end
            if (!found || sq_dist < best_dist)
            begin
                found = 1;
                best_dist = sq_dist;
                best = c;
            end
        end
        if (found && best_dist < longint'(thr) * longint'(thr)
            && members[best] < branch * 10)
        begin
            for (int d = 0; d < 4; d++)
                sums[best][d] += pt[d];
            members[best]++;
            r.cluster_index = 6'(best);
        end
        else if (used < 64)
        begin
            for (int d = 0; d < 4; d++)
                sums[used][d] = pt[d];
            members[used] = 1;
            r.cluster_index = 6'(used);
            r.created_new = 1;
            used++;
        end
        else
            r.dropped = 1;
        r.cluster_count = 7'(used);
        r.set_done = last;
        if (last)
            used = 0;
        expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_result(assign_t got);
        assign_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("unexpected result, queue depth", 0, 1);
            return;
        end
        want = expected_q.pop_front();
        if (got.cluster_index !== want.cluster_index)
            report_mismatch("cluster_index", got.cluster_index, want.cluster_index);
        if (got.created_new !== want.created_new)
            report_mismatch("created_new", got.created_new, want.created_new);
        if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
        if (got.cluster_count !== want.cluster_count)
            report_mismatch("cluster_count", got.cluster_count, want.cluster_count);
        if (got.set_done !== want.set_done)
            report_mismatch("set_done", got.set_done, want.set_done);
    endtask
endclass

module online_threshold_clusterer_tb;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic        pt_valid = 0;
    logic        pt_ready;
    logic signed [15:0] coord_0 = 0, coord_1 = 0, coord_2 = 0, coord_3 = 0;
    logic        last_point = 0;
    logic        res_valid;
    logic        res_ready = 0;
    logic [5:0]  cluster_index;
    logic        created_new;
    logic        dropped;
    logic [6:0]  cluster_count;
    logic        set_done;

    cluster_scoreboard sb = new();
    int idle_mode = IDLE_NONE;
    logic hold_start = 0;
    logic hold_taken = 0;
    int hold_cycles = 0;

    always #6 clk = ~clk;

    online_threshold_clusterer DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pt_valid(pt_valid), .pt_ready(pt_ready),
        .coord_0(coord_0), .coord_1(coord_1), .coord_2(coord_2), .coord_3(coord_3),
        .last_point(last_point),
        .res_valid(res_valid), .res_ready(res_ready),
        .cluster_index(cluster_index), .created_new(created_new), .dropped(dropped),
        .cluster_count(cluster_count), .set_done(set_done)
    );

    // Receiver side: stall pattern plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_start && !hold_taken)
        begin
            hold_taken <= 1;
            hold_cycles <= 3000;
            res_ready <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_ready <= 0;
        end
        else if (idle_mode == IDLE_RECV)
            res_ready <= ($urandom_range(99) >= 67);
        else if (idle_mode == IDLE_BOTH)
            res_ready <= ($urandom_range(99) >= 33);
        else
            res_ready <= 1;
    end

    always @(posedge clk)
    begin
        assign_t got;
        if (rst_n && res_valid && res_ready)
        begin
            got.cluster_index = cluster_index;
            got.created_new   = created_new;
            got.dropped       = dropped;
            got.cluster_count = cluster_count;
            got.set_done      = set_done;
            sb.check_result(got);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_point(logic [3:0][15:0] crd, logic last);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SEND) ? 67 : (idle_mode == IDLE_BOTH) ? 33 : 0;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            pt_valid <= 0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        coord_0 <= crd[0];
        coord_1 <= crd[1];
        coord_2 <= crd[2];
        coord_3 <= crd[3];
        last_point <= last;
        pt_valid <= 1;
        do
            @(posedge clk);
        while (!pt_ready);
        sb.note_point(crd, last);
        @(negedge clk);
    endtask

    task write_reg(logic idx, logic [15:0] data);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_register(idx, data);
        @(negedge clk);
    endtask

    task drain();
        pt_valid <= 0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function logic [15:0] clamp16(int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function logic [3:0][15:0] pt4(int a, int b, int c, int d);
        return {clamp16(d), clamp16(c), clamp16(b), clamp16(a)};
    endfunction

    // One data set: points jittered around a few random centers, some noise.
    task run_set(int npts, int ncent, int spread);
        logic [3:0][15:0] centers [$];
        logic [3:0][15:0] p;
        logic [3:0][15:0] ctr;
        for (int k = 0; k < ncent; k++)
            centers.push_back({$urandom, $urandom});
        for (int i = 0; i < npts; i++)
        begin
            if ($urandom_range(99) < 8)
                p = {$urandom, $urandom};
            else
            begin
                ctr = centers[$urandom_range(ncent - 1)];
                for (int d = 0; d < 4; d++)
                    p[d] = clamp16(int'($signed(ctr[d]))
                                   + $urandom_range(2 * spread) - spread);
            end
            send_point(p, i == npts - 1);
        end
    endtask

    // Many distinct points along a line so the table fills and drops occur.
    task run_fill_set(int npts);
        for (int i = 0; i < npts; i++)
            send_point(pt4(i * 700 - 32000, -i * 500, i * 300, 1000), i == npts - 1);
    endtask

    task run_phase(logic [15:0] thr_w, logic [15:0] br_w, int mode, int npts);
        int sent, n, spread;
        write_reg(otc_pkg::REG_THRESHOLD, thr_w);
        write_reg(otc_pkg::REG_BRANCH_FACTOR, br_w);
        idle_mode = mode;
        sent = 0;
        spread = (sb.thr > 512) ? 256 : sb.thr / 2;
        while (sent < npts)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 25);
            run_set(n, $urandom_range(1, 6), spread);
            sent += n;
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: extremes, empty table, closest-wins, tie to lowest index.
        send_point(pt4(32767, 32767, 32767, 32767), 0);
        send_point(pt4(-32768, -32768, -32768, -32768), 0);
        send_point(pt4(0, 0, 0, 0), 0);
        send_point(pt4(32767, 32767, 32767, 32767), 0);
        send_point(pt4(32767, -32768, 32767, -32768), 1);
        send_point(pt4(200, 0, 0, 0), 0);
        send_point(pt4(-200, 0, 0, 0), 0);
        send_point(pt4(0, 0, 0, 0), 0);
        send_point(pt4(0, 1, -1, 0), 1);
        send_point(pt4(-1, -1, -1, -1), 1);
        drain();

        // threshold 1, branch clamp from below, table overflow
        write_reg(otc_pkg::REG_THRESHOLD, 16'd1);
        write_reg(otc_pkg::REG_BRANCH_FACTOR, 16'd1);
        run_fill_set(72);
        drain();
        // branch 2: identical points hit the member limit of 20
        write_reg(otc_pkg::REG_BRANCH_FACTOR, 16'd2);
        write_reg(otc_pkg::REG_THRESHOLD, 16'd300);
        for (int i = 0; i < 24; i++)
            send_point(pt4(50, -50, 50, -50), i == 23);
        drain();

        run_phase(16'd65535, 16'd100, IDLE_SEND, 140);
        hold_start = 1;
        run_phase(16'd0, 16'h007F, IDLE_RECV, 140);
        run_phase(16'd300, 16'd2, IDLE_BOTH, 140);
        run_phase(16'd1024, 16'h0080, IDLE_NONE, 120);
        run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(2, 100)),
                  IDLE_SEND, 100);

        if (sb.errors == 0)
            $display("online_threshold_clusterer test passed");
        else
            $display("online_threshold_clusterer test failed");
        $finish;
    end

    initial
    begin
        #(12 * 4000000);
        $display("online_threshold_clusterer test failed");
        $finish;
    end

endmodule

`default_nettype wire
